// ----- design/bpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the barometer compensation pipe.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam logic [31:0] TF_OFFSET  = 32'd64000;
  localparam logic [31:0] P_BASE     = 32'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [31:0] P_HALF     = 32'h8000_0000;
  localparam logic [31:0] P1_BIAS    = 32'd32768;
  localparam logic [31:0] T_ROUND    = 32'd128;
  localparam int          DIV_BITS   = 32;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  // calibration words, sign extended where signed
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/bpc_temp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_temp
// Temperature compensation, five stages; also yields the pressure offset term.
// ----------------------------------------------------------------------------
module bpc_temp import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire coef_t       cf,
  input  wire logic        v_in,
  input  wire logic [19:0] adc_p,
  input  wire logic [19:0] adc_t,
  output logic             v_out,
  output logic [31:0]      temp_out,
  output logic [31:0]      pa_out,
  output logic [31:0]      d2_out,
  output logic [19:0]      adcp_out
);
  logic [4:0]  v_r;
  logic [19:0] adcp_r [0:4];
  logic [31:0] x1_r, dd_r, ma_r, dd2_r, a_r, mb_r, fine_r, temp_r, pa_r, d2_r;
  logic [31:0] t_ext, fine_nxt;

  assign t_ext    = {12'd0, adc_t};
  assign fine_nxt = a_r + asr(mb_r, 14);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adcp_r[0] <= adc_p;
      for (int i = 1; i < 5; i++) adcp_r[i] <= adcp_r[i-1];
      x1_r   <= (t_ext >> 3) - (cf.t1 << 1);
      dd_r   <= (t_ext >> 4) - cf.t1;
      ma_r   <= mul32(x1_r, cf.t2);
      dd2_r  <= mul32(dd_r, dd_r);
      a_r    <= asr(ma_r, 11);
      mb_r   <= mul32(asr(dd2_r, 12), cf.t3);
      fine_r <= fine_nxt;
      temp_r <= asr(mul32(fine_r, 32'd5) + T_ROUND, 8);
      pa_r   <= asr(fine_r, 1) - TF_OFFSET;
      d2_r   <= asr(asr(fine_r, 1) - TF_OFFSET, 2);
    end
  end

  assign v_out    = v_r[4];
  assign temp_out = temp_r;
  assign pa_out   = pa_r;
  assign d2_out   = d2_r;
  assign adcp_out = adcp_r[4];

endmodule
`default_nettype wire

// ----- design/bpc_coef.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_coef
// Pressure divisor and scaled numerator, six stages.
// ----------------------------------------------------------------------------
module bpc_coef import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire coef_t       cf,
  input  wire logic        v_in,
  input  wire logic [31:0] temp_in,
  input  wire logic [31:0] pa,
  input  wire logic [31:0] d2,
  input  wire logic [19:0] adc_p,
  output logic             v_out,
  output logic [31:0]      temp_out,
  output logic [31:0]      num_out,
  output logic [31:0]      den_out
);
  logic [5:0]  v_r;
  logic [31:0] temp_r [0:5];
  logic [19:0] adcp_r [0:3];
  logic [31:0] dd_r, ma5_r, mp2_r, b6_r, c3_r, ma5b_r, mp2b_r;
  logic [31:0] b_r, a_r, a1_r, b2_r, den_r, num_r, p_r;
  logic [31:0] b_nxt;

  assign b_nxt = b6_r + (ma5b_r << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp_r[0] <= temp_in;
      for (int i = 1; i < 6; i++) temp_r[i] <= temp_r[i-1];
      adcp_r[0] <= adc_p;
      for (int i = 1; i < 4; i++) adcp_r[i] <= adcp_r[i-1];
      dd_r   <= mul32(d2, d2);
      ma5_r  <= mul32(pa, cf.p5);
      mp2_r  <= mul32(cf.p2, pa);
      b6_r   <= mul32(asr(dd_r, 11), cf.p6);
      c3_r   <= mul32(cf.p3, asr(dd_r, 13));
      ma5b_r <= ma5_r;
      mp2b_r <= mp2_r;
      b_r    <= asr(b_nxt, 2) + (cf.p4 << 16);
      a_r    <= asr(asr(c3_r, 3) + asr(mp2b_r, 1), 18);
      a1_r   <= mul32(P1_BIAS + a_r, cf.p1);
      b2_r   <= b_r;
      den_r  <= asr(a1_r, 15);
      num_r  <= (P_BASE - {12'd0, adcp_r[3]}) - asr(b2_r, 12);
      p_r    <= mul32(num_r, P_SCALE);
    end
  end

  // divisor is one stage ahead of the product; hold it aligned
  logic [31:0] den2_r;
  always_ff @(posedge clk) begin
    if (adv) den2_r <= den_r;
  end

  assign v_out    = v_r[5];
  assign temp_out = temp_r[5];
  assign num_out  = p_r;
  assign den_out  = den2_r;

endmodule
`default_nettype wire

// ----- design/bpc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        v_in,
  input  wire logic [31:0] temp_in,
  input  wire logic [31:0] p_in,
  input  wire logic [31:0] den_in,
  output logic             v_out,
  output logic [31:0]      temp_out,
  output logic [31:0]      quo_out,
  output logic             dbl_out,
  output logic             inv_out
);
  logic [DIV_BITS:0] v_r;
  logic [31:0] rem_r  [0:DIV_BITS];
  logic [31:0] quo_r  [0:DIV_BITS];
  logic [31:0] num_r  [0:DIV_BITS];
  logic [31:0] den_r  [0:DIV_BITS];
  logic [31:0] temp_r [0:DIV_BITS];
  logic        dbl_r  [0:DIV_BITS];
  logic        inv_r  [0:DIV_BITS];
  logic [32:0]         trial   [0:DIV_BITS-1];
  logic [31:0]         rem_nxt [0:DIV_BITS-1];
  logic [DIV_BITS-1:0] ge;

  // per stage: bring down one numerator bit, subtract when it fits
  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      trial[k]   = {rem_r[k], num_r[k][DIV_BITS-1-k]};
      ge[k]      = trial[k] >= {1'b0, den_r[k]};
      rem_nxt[k] = ge[k] ? 32'(trial[k] - {1'b0, den_r[k]}) : trial[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DIV_BITS-1:0], v_in};
    end
  end

  // entry: large products are divided first and doubled after
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= '0;
      num_r[0]  <= (p_in < P_HALF) ? (p_in << 1) : p_in;
      dbl_r[0]  <= !(p_in < P_HALF);
      den_r[0]  <= den_in;
      inv_r[0]  <= (den_in == '0);
      temp_r[0] <= temp_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        quo_r[k+1]  <= {quo_r[k][30:0], ge[k]};
        num_r[k+1]  <= num_r[k];
        den_r[k+1]  <= den_r[k];
        dbl_r[k+1]  <= dbl_r[k];
        inv_r[k+1]  <= inv_r[k];
        temp_r[k+1] <= temp_r[k];
      end
    end
  end

  assign v_out    = v_r[DIV_BITS];
  assign temp_out = temp_r[DIV_BITS];
  assign quo_out  = quo_r[DIV_BITS];
  assign dbl_out  = dbl_r[DIV_BITS];
  assign inv_out  = inv_r[DIV_BITS];

endmodule
`default_nettype wire

// ----- design/bpc_post.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_post
// Second-order pressure correction, three stages ending in the output word.
// ----------------------------------------------------------------------------
module bpc_post import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire coef_t       cf,
  input  wire logic        v_in,
  input  wire logic [31:0] temp_in,
  input  wire logic [31:0] quo,
  input  wire logic        dbl,
  input  wire logic        inv,
  output logic             v_out,
  output logic [31:0]      temp_out,
  output logic [31:0]      press_out,
  output logic             pvalid_out
);
  logic [2:0]  v_r;
  logic [31:0] temp_r [0:2];
  logic        inv_r  [0:1];
  logic [31:0] p_r, p2_r, dd_r, m9_r, m8_r, press_r;
  logic        pval_r;
  logic [31:0] p_nxt, d_nxt, corr;

  assign p_nxt = dbl ? (quo << 1) : quo;
  assign d_nxt = p_nxt >> 3;
  assign corr  = asr(asr(m9_r, 12) + asr(m8_r, 13) + cf.p7, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp_r[0] <= temp_in;
      temp_r[1] <= temp_r[0];
      temp_r[2] <= temp_r[1];
      inv_r[0]  <= inv;
      inv_r[1]  <= inv_r[0];
      p_r       <= p_nxt;
      dd_r      <= mul32(d_nxt, d_nxt);
      m9_r      <= mul32(cf.p9, dd_r >> 13);
      m8_r      <= mul32(p_r >> 2, cf.p8);
      p2_r      <= p_r;
      press_r   <= inv_r[1] ? '0 : p2_r + corr;
      pval_r    <= !inv_r[1];
    end
  end

  assign v_out      = v_r[2];
  assign temp_out   = temp_r[2];
  assign press_out  = press_r;
  assign pvalid_out = pval_r;

endmodule
`default_nettype wire

// ----- design/baro_temp_pressure_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 47 register stages (5 temperature, 6 coefficient, 33 divider,
//   3 correction stages).
// Throughput: one word per cycle while the output is not stalled; set by the
//   pipelined divider, one quotient bit per stage, and the pipelined multipliers.
// The whole pipe advances together; it halts only while the output word waits.
// Reset (rst_n, synchronous): clears valid bits and calibration registers.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// 32-bit integer temperature/pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // temperature_centi[31:0], pressure_pa[63:32]
  output logic             out_tuser   // pressure_valid
);
  // calibration registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r, press_b_r;
  logic [15:0] press_c_r;
  coef_t       cf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP:    temp_coeffs_r <= cfg_wdata[47:0];
        REG_PRESS_A: press_a_r     <= cfg_wdata;
        REG_PRESS_B: press_b_r     <= cfg_wdata;
        REG_PRESS_C: press_c_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cf.t1 = {16'd0, temp_coeffs_r[15:0]};
    cf.t2 = sx16(temp_coeffs_r[31:16]);
    cf.t3 = sx16(temp_coeffs_r[47:32]);
    cf.p1 = {16'd0, press_a_r[15:0]};
    cf.p2 = sx16(press_a_r[31:16]);
    cf.p3 = sx16(press_a_r[47:32]);
    cf.p4 = sx16(press_a_r[63:48]);
    cf.p5 = sx16(press_b_r[15:0]);
    cf.p6 = sx16(press_b_r[31:16]);
    cf.p7 = sx16(press_b_r[47:32]);
    cf.p8 = sx16(press_b_r[63:48]);
    cf.p9 = sx16(press_c_r);
  end

  // global advance: the output register is free or being drained
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic        v1, v2, v3;
  logic [31:0] temp1, pa1, d21, temp2, num2, den2, temp3, quo3;
  logic [19:0] adcp1;
  logic        dbl3, inv3;
  logic [31:0] temp_o, press_o;
  logic        pval_o;

  bpc_temp u_temp (
    .clk, .rst_n, .adv, .cf,
    .v_in(in_tvalid), .adc_p(in_tdata[19:0]), .adc_t(in_tdata[39:20]),
    .v_out(v1), .temp_out(temp1), .pa_out(pa1), .d2_out(d21), .adcp_out(adcp1)
  );

  bpc_coef u_coef (
    .clk, .rst_n, .adv, .cf,
    .v_in(v1), .temp_in(temp1), .pa(pa1), .d2(d21), .adc_p(adcp1),
    .v_out(v2), .temp_out(temp2), .num_out(num2), .den_out(den2)
  );

  bpc_div u_div (
    .clk, .rst_n, .adv,
    .v_in(v2), .temp_in(temp2), .p_in(num2), .den_in(den2),
    .v_out(v3), .temp_out(temp3), .quo_out(quo3), .dbl_out(dbl3), .inv_out(inv3)
  );

  bpc_post u_post (
    .clk, .rst_n, .adv, .cf,
    .v_in(v3), .temp_in(temp3), .quo(quo3), .dbl(dbl3), .inv(inv3),
    .v_out(out_tvalid), .temp_out(temp_o), .press_out(press_o), .pvalid_out(pval_o)
  );

  assign out_tdata = {press_o, temp_o};
  assign out_tuser = pval_o;

endmodule
`default_nettype wire
